// ===== src/sha256sh_pkg.sv =====
// Package with SHA-256 constants and transaction types for the stream hasher.
`default_nettype none
package sha256sh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_number;
    logic        last_word;
  } out_item_t;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned RoundW = $clog2(NumRounds);
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned amt);
    return (v >> amt) | (v << (32 - amt));
  endfunction

endpackage
`default_nettype wire

// ===== src/sha256_stream_hasher.sv =====
// SHA-256 stream hasher: byte collection, padding, iterative compression, digest output.
`default_nettype none
// Takes one optional message byte per transaction and returns the SHA-256 digest as four
// 64-bit words, most significant first, after a transaction with end_of_message set. Bytes
// shift into a 512-bit block register, one per transaction; in_ready stays high until the
// 64th byte, then drops while one shared round unit runs the 64 rounds (one per cycle) and
// the result is folded into the chaining value; no byte is taken during a compression.
// Closing a message shifts the pad and length in one byte per cycle to the end of the
// block (or over two blocks when the length spills into a second block), runs one or two
// compressions and then presents the four digest transactions; in_ready returns after the
// last one is taken.
module sha256_stream_hasher
  import sha256sh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [511:0]       blk_r, blk_nxt;
  logic [31:0]        hash_r [8];
  logic [31:0]        hash_nxt [8];
  logic [31:0]        work_r [8];
  logic [31:0]        work_nxt [8];
  logic [5:0]         fill_r, fill_nxt;
  logic [63:0]        bitlen_r, bitlen_nxt;
  logic [RoundW-1:0]  rnd_r, rnd_nxt;
  logic [1:0]         word_r, word_nxt;
  logic               fin_r, fin_nxt;
  logic               pad80_r, pad80_nxt;
  logic               extra_r, extra_nxt;
  logic               last_blk_r, last_blk_nxt;

  logic [31:0] w0, w1, w9, w14, sig0, sig1, w_new;
  logic [31:0] big0, big1, chs, maj, t1, t2;
  logic [7:0]  len_byte, pad_byte;
  logic [5:0]  len_sh;
  logic        in_acc, out_acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  assign out_data.digest_word = {hash_r[{word_r, 1'b0}], hash_r[{word_r, 1'b1}]};
  assign out_data.word_number = word_r;
  assign out_data.last_word   = (word_r == 2'd3);

  // schedule window taps: W[t], W[t+1], W[t+9], W[t+14]
  assign w0    = blk_r[511:480];
  assign w1    = blk_r[479:448];
  assign w9    = blk_r[223:192];
  assign w14   = blk_r[63:32];
  assign sig0  = ror32(w1, 7) ^ ror32(w1, 18) ^ (w1 >> 3);
  assign sig1  = ror32(w14, 17) ^ ror32(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + sig0 + w9 + sig1;

  assign big1 = ror32(work_r[4], 6) ^ ror32(work_r[4], 11) ^ ror32(work_r[4], 25);
  assign chs  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign t1   = work_r[7] + big1 + chs + RoundK[rnd_r] + w0;
  assign big0 = ror32(work_r[0], 2) ^ ror32(work_r[0], 13) ^ ror32(work_r[0], 22);
  assign maj  = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t2   = big0 + maj;

  assign len_sh   = {~fill_r[2:0], 3'b000};
  assign len_byte = 8'(bitlen_r >> len_sh);

  always_comb begin
    if (!pad80_r) begin
      pad_byte = PadByte;
    end else if (extra_r || (fill_r < LenStart)) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = len_byte;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    blk_nxt      = blk_r;
    hash_nxt     = hash_r;
    work_nxt     = work_r;
    fill_nxt     = fill_r;
    bitlen_nxt   = bitlen_r;
    rnd_nxt      = rnd_r;
    word_nxt     = word_r;
    fin_nxt      = fin_r;
    pad80_nxt    = pad80_r;
    extra_nxt    = extra_r;
    last_blk_nxt = last_blk_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          fin_nxt = in_data.end_of_message;
          if (in_data.has_byte) begin
            blk_nxt    = {blk_r[503:0], in_data.data_byte};
            fill_nxt   = fill_r + 6'd1;
            bitlen_nxt = bitlen_r + 64'd8;
          end
          if (in_data.has_byte && (fill_r == 6'd63)) begin
            state_nxt    = ST_ROUND;
            work_nxt     = hash_r;
            rnd_nxt      = '0;
            last_blk_nxt = 1'b0;
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        blk_nxt  = {blk_r[503:0], pad_byte};
        fill_nxt = fill_r + 6'd1;
        if (!pad80_r) begin
          pad80_nxt = 1'b1;
          extra_nxt = (fill_r >= LenStart);
        end
        if (fill_r == 6'd63) begin
          state_nxt    = ST_ROUND;
          work_nxt     = hash_r;
          rnd_nxt      = '0;
          last_blk_nxt = pad80_r && !extra_r;
          extra_nxt    = 1'b0;
        end
      end
      ST_ROUND: begin
        blk_nxt     = {blk_r[479:0], w_new};
        work_nxt[7] = work_r[6];
        work_nxt[6] = work_r[5];
        work_nxt[5] = work_r[4];
        work_nxt[4] = work_r[3] + t1;
        work_nxt[3] = work_r[2];
        work_nxt[2] = work_r[1];
        work_nxt[1] = work_r[0];
        work_nxt[0] = t1 + t2;
        rnd_nxt     = rnd_r + 1'b1;
        if (rnd_r == RoundW'(NumRounds - 1)) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + work_r[i];
        end
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (last_blk_r) begin
          state_nxt = ST_OUT;
          word_nxt  = '0;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          word_nxt = word_r + 2'd1;
          if (word_r == 2'd3) begin
            state_nxt  = ST_IDLE;
            hash_nxt   = InitHash;
            fill_nxt   = '0;
            bitlen_nxt = '0;
            fin_nxt    = 1'b0;
            pad80_nxt  = 1'b0;
            extra_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      hash_r     <= InitHash;
      fill_r     <= '0;
      bitlen_r   <= '0;
      rnd_r      <= '0;
      word_r     <= '0;
      fin_r      <= 1'b0;
      pad80_r    <= 1'b0;
      extra_r    <= 1'b0;
      last_blk_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      hash_r     <= hash_nxt;
      fill_r     <= fill_nxt;
      bitlen_r   <= bitlen_nxt;
      rnd_r      <= rnd_nxt;
      word_r     <= word_nxt;
      fin_r      <= fin_nxt;
      pad80_r    <= pad80_nxt;
      extra_r    <= extra_nxt;
      last_blk_r <= last_blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    work_r <= work_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels active together");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) && (rnd_r == RoundW'(NumRounds - 1)) |=> (state_r == ST_FOLD))
    else $error("round sequence did not end in fold");

  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    last_blk_r && (state_r == ST_ROUND) |-> fin_r && pad80_r)
    else $error("final block compressed without an open close");

  a_digest_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (word_r == 2'd3) |=> (fill_r == '0) && (bitlen_r == '0) && in_ready)
    else $error("state not cleared after digest");

  a_pad_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (fill_r == '0))
    else $error("digest presented with partial block");

endmodule
`default_nettype wire
